>>> hdl/packed_point_number_decoder_core_assert.svh
// Assertion macros for the packed point-number decoder.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef PACKED_POINT_NUMBER_DECODER_CORE_ASSERT_SVH
`define PACKED_POINT_NUMBER_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPND_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppnd assertion failed");
// next-cycle implication
`define PPND_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppnd assertion failed");
`else
`define PPND_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPND_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/ppnd_pkg.sv
// Shared types and constants of the packed point-number decoder.
// No dependencies.
package ppnd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned NUM_W   = 31;
  localparam int unsigned BCNT_W  = 17;
  localparam int unsigned ERR_W   = 2;

  localparam logic [COUNT_W-1:0] CAP_RESET = 15'h7FFF;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BUFFER  = 2'd2;

  typedef struct packed {
    logic [NUM_W-1:0]   point_number;
    logic [COUNT_W-1:0] point_index;
    logic               point_valid;
    logic               record_done;
    logic               full_set;
    logic [COUNT_W-1:0] point_total;
    logic [BCNT_W-1:0]  used_bytes;
    logic [ERR_W-1:0]   error_code;
  } ppnd_result_t;

endpackage

>>> hdl/ppnd_in_if.sv
// Input byte channel of the packed point-number decoder.
// Depends on ppnd_pkg.
interface ppnd_in_if;
  import ppnd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              record_start;
  logic              data_end;

  modport source(output valid, output data_byte, output record_start, output data_end,
                 input ready);
  modport sink(input valid, input data_byte, input record_start, input data_end,
               output ready);
endinterface

>>> hdl/ppnd_out_if.sv
// Result channel of the packed point-number decoder.
// Depends on ppnd_pkg.
interface ppnd_out_if;
  import ppnd_pkg::*;

  logic               valid;
  logic               ready;
  logic [NUM_W-1:0]   point_number;
  logic [COUNT_W-1:0] point_index;
  logic               point_valid;
  logic               record_done;
  logic               full_set;
  logic [COUNT_W-1:0] point_total;
  logic [BCNT_W-1:0]  used_bytes;
  logic [ERR_W-1:0]   error_code;

  modport source(output valid, output point_number, output point_index, output point_valid,
                 output record_done, output full_set, output point_total,
                 output used_bytes, output error_code, input ready);
  modport sink(input valid, input point_number, input point_index, input point_valid,
               input record_done, input full_set, input point_total,
               input used_bytes, input error_code, output ready);
endinterface

>>> hdl/packed_point_number_decoder_core.sv
// Packed point-number decoder top level: config register, parser, result buffer.
// Depends on ppnd_pkg, ppnd_in_if, ppnd_out_if, ppnd_decode, ppnd_skid and the
// assertion header.
//
// Usage:
//   byte_in carries one raw byte of a packed point-number record per beat,
//   with record_start on the first byte of a record and data_end on the last
//   byte available. point_out carries at most one result per input beat: a
//   decoded point, a record completion, or both at once. On completion the
//   beat carries error_code, point_total and used_bytes; when the error is
//   nonzero the consumer drops the record's points. cfg_we is ungated; the user
//   must write buffer_capacity via cfg_we/cfg_wdata only while the block idles.
// Timing:
//   One byte is decoded per cycle while byte_in.ready is high; with point_out
//   ready, a result appears the cycle after its byte is accepted. Sustained
//   rate is one byte per cycle with point_out ready; the running sum is 31-bit.
// Reset and stall:
//   rst clears the record state, empties the result buffer and sets the
//   capacity to 32767. When point_out stalls, one more result is held in a
//   skid entry; byte_in.ready then drops until point_out takes the held beat.
module packed_point_number_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ppnd_pkg::COUNT_W-1:0] cfg_wdata,
  ppnd_in_if.sink                      byte_in,
  ppnd_out_if.source                   point_out
);
  import ppnd_pkg::*;

`include "packed_point_number_decoder_core_assert.svh"

  logic [COUNT_W-1:0] buffer_capacity;
  logic               take;
  logic               room;
  logic               res_valid;
  ppnd_result_t       res;
  logic               out_valid;
  ppnd_result_t       out_data;
  logic               chk_nopoint;
  logic               chk_invalid;
  logic               chk_invalid_clear;
  logic               chk_allp;
  logic               chk_allp_ok;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      buffer_capacity <= cfg_wdata;
    end
  end

  assign byte_in.ready = room;
  assign take          = byte_in.valid && room;

  ppnd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .capacity     (buffer_capacity),
    .take         (take),
    .data_byte    (byte_in.data_byte),
    .record_start (byte_in.record_start),
    .data_end     (byte_in.data_end),
    .res_valid    (res_valid),
    .res          (res)
  );

  ppnd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (point_out.ready)
  );

  // Drive the result channel
  assign point_out.valid        = out_valid;
  assign point_out.point_number = out_data.point_number;
  assign point_out.point_index  = out_data.point_index;
  assign point_out.point_valid  = out_data.point_valid;
  assign point_out.record_done  = out_data.record_done;
  assign point_out.full_set     = out_data.full_set;
  assign point_out.point_total  = out_data.point_total;
  assign point_out.used_bytes   = out_data.used_bytes;
  assign point_out.error_code   = out_data.error_code;

  // Form the terms of the checks below
  assign chk_nopoint       = out_valid && !out_data.point_valid;
  assign chk_invalid       = out_valid && out_data.error_code == ERR_INVALID;
  assign chk_invalid_clear = out_data.point_total == '0 && out_data.used_bytes == '0;
  assign chk_allp          = out_valid && out_data.full_set;
  assign chk_allp_ok       = out_data.record_done && out_data.point_total == '0 &&
                             !out_data.point_valid;

  // A beat with no point must close a record
  `PPND_ASSERT_IMP(a_nopoint_done, clk, rst, chk_nopoint, out_data.record_done)
  // An invalid record reports no count and no byte total
  `PPND_ASSERT_IMP(a_invalid_clear, clk, rst, chk_invalid, chk_invalid_clear)
  // An all-points header completes at once with a zero count
  `PPND_ASSERT_IMP(a_allp_done, clk, rst, chk_allp, chk_allp_ok)
  // Input stalls only while results wait
  `PPND_ASSERT_IMP(a_stall_cause, clk, rst, !room, out_valid)
  // A held result that is not taken stays for the next cycle
  `PPND_ASSERT_NEXT(a_held, clk, rst, out_valid && !point_out.ready, out_valid)

endmodule

>>> hdl/ppnd_decode.sv
// Record parser: holds the per-record state and decodes one byte per beat.
// Depends on ppnd_pkg; the result it forms is registered by ppnd_skid.
module ppnd_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ppnd_pkg::COUNT_W-1:0] capacity,
  input  logic                         take,
  input  logic [ppnd_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         record_start,
  input  logic                         data_end,
  output logic                         res_valid,
  output ppnd_pkg::ppnd_result_t       res
);
  import ppnd_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_BYTE = 3'd4;
  localparam logic [2:0] PH_WHI  = 3'd5;
  localparam logic [2:0] PH_WLO  = 3'd6;

  logic [2:0]         phase;
  logic [6:0]         header_high;
  logic [COUNT_W-1:0] total_count;
  logic [COUNT_W-1:0] emitted_count;
  logic [7:0]         run_left;
  logic               word_mode;
  logic [7:0]         high_byte;
  logic [NUM_W-1:0]   running_sum;
  logic [BCNT_W-1:0]  byte_counter;
  logic               over_capacity;

  logic [2:0]         phase_next;
  logic [6:0]         header_high_next;
  logic [COUNT_W-1:0] total_count_next;
  logic [COUNT_W-1:0] emitted_count_next;
  logic [7:0]         run_left_next;
  logic               word_mode_next;
  logic [7:0]         high_byte_next;
  logic [NUM_W-1:0]   running_sum_next;
  logic [BCNT_W-1:0]  byte_counter_next;
  logic               over_capacity_next;

  // working copies after a possible record restart
  logic [2:0]         ph_w;
  logic [COUNT_W-1:0] emt_w;
  logic [COUNT_W-1:0] tot_w;
  logic [7:0]         rl_w;
  logic               wm_w;
  logic [6:0]         hh_w;
  logic [7:0]         hb_w;
  logic [NUM_W-1:0]   sum_w;
  logic [BCNT_W-1:0]  bc_w;
  logic               ovc_w;

  logic               use_cnt;
  logic [COUNT_W-1:0] cnt;
  logic               use_delta;
  logic [15:0]        delta;
  logic [7:0]         run;
  logic [COUNT_W-1:0] remaining;
  logic               done;
  logic               pvalid;
  logic               allp;
  logic [ERR_W-1:0]   err;

  // Decode one byte against the current record state
  always_comb begin
    if (record_start) begin
      ph_w  = PH_HEAD;
      emt_w = '0;
      tot_w = '0;
      rl_w  = '0;
      wm_w  = 1'b0;
      hh_w  = '0;
      hb_w  = '0;
      sum_w = '0;
      bc_w  = '0;
      ovc_w = 1'b0;
    end else begin
      ph_w  = phase;
      emt_w = emitted_count;
      tot_w = total_count;
      rl_w  = run_left;
      wm_w  = word_mode;
      hh_w  = header_high;
      hb_w  = high_byte;
      sum_w = running_sum;
      bc_w  = byte_counter;
      ovc_w = over_capacity;
    end

    phase_next         = ph_w;
    header_high_next   = hh_w;
    total_count_next   = tot_w;
    emitted_count_next = emt_w;
    run_left_next      = rl_w;
    word_mode_next     = wm_w;
    high_byte_next     = hb_w;
    running_sum_next   = sum_w;
    byte_counter_next  = bc_w + BCNT_W'(1);
    over_capacity_next = ovc_w;

    use_cnt   = 1'b0;
    cnt       = '0;
    use_delta = 1'b0;
    delta     = '0;
    run       = {1'b0, data_byte[6:0]} + 8'd1;
    remaining = tot_w - emt_w;
    done      = 1'b0;
    pvalid    = 1'b0;
    allp      = 1'b0;
    err       = ERR_NONE;
    res       = '0;

    case (ph_w)
      PH_HEAD: begin
        if (data_byte == '0) begin
          done = 1'b1;
          allp = 1'b1;
        end else if (data_byte[7]) begin
          header_high_next = data_byte[6:0];
          phase_next       = PH_HDR2;
        end else begin
          use_cnt = 1'b1;
          cnt     = {8'd0, data_byte[6:0]};
        end
      end
      PH_HDR2: begin
        use_cnt = 1'b1;
        cnt     = {hh_w, data_byte};
      end
      PH_CTRL: begin
        if ({7'd0, run} > remaining) begin
          done = 1'b1;
          err  = ERR_INVALID;
        end else begin
          run_left_next  = run;
          word_mode_next = data_byte[7];
          phase_next     = data_byte[7] ? PH_WHI : PH_BYTE;
        end
      end
      PH_BYTE: begin
        use_delta = 1'b1;
        delta     = {8'd0, data_byte};
      end
      PH_WHI: begin
        high_byte_next = data_byte;
        phase_next     = PH_WLO;
      end
      PH_WLO: begin
        use_delta = 1'b1;
        delta     = {hb_w, data_byte};
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Latch the header count and check it against the buffer
    if (use_cnt) begin
      total_count_next   = cnt;
      over_capacity_next = (cnt > capacity);
      if (cnt == '0) begin
        done = 1'b1;
      end else begin
        phase_next = PH_CTRL;
      end
    end

    // Accumulate a delta and emit the point
    if (use_delta) begin
      running_sum_next   = sum_w + {{(NUM_W-16){1'b0}}, delta};
      pvalid             = 1'b1;
      emitted_count_next = emt_w + COUNT_W'(1);
      run_left_next      = rl_w - 8'd1;
      if (emitted_count_next == tot_w) begin
        done = 1'b1;
      end else if (run_left_next == '0) begin
        phase_next = PH_CTRL;
      end else begin
        phase_next = wm_w ? PH_WHI : PH_BYTE;
      end
    end

    // Truncation, then close the record
    if (ph_w != PH_IDLE && !done && data_end) begin
      done = 1'b1;
      err  = ERR_INVALID;
    end
    if (done) begin
      phase_next = PH_IDLE;
      if (err == ERR_NONE && over_capacity_next) begin
        err = ERR_BUFFER;
      end
    end

    res_valid        = take && (pvalid || done);
    res.point_number = pvalid ? running_sum_next : '0;
    res.point_index  = pvalid ? emt_w : '0;
    res.point_valid  = pvalid;
    res.record_done  = done;
    res.full_set     = allp;
    res.point_total  = (done && err != ERR_INVALID) ? total_count_next : '0;
    res.used_bytes   = (done && err == ERR_NONE) ? byte_counter_next : '0;
    res.error_code   = err;
  end

  // Advance the record state on each accepted beat that starts or continues a record
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_high   <= '0;
      total_count   <= '0;
      emitted_count <= '0;
      run_left      <= '0;
      word_mode     <= 1'b0;
      high_byte     <= '0;
      running_sum   <= '0;
      byte_counter  <= '0;
      over_capacity <= 1'b0;
    end else if (take && (record_start || phase != PH_IDLE)) begin
      phase         <= phase_next;
      header_high   <= header_high_next;
      total_count   <= total_count_next;
      emitted_count <= emitted_count_next;
      run_left      <= run_left_next;
      word_mode     <= word_mode_next;
      high_byte     <= high_byte_next;
      running_sum   <= running_sum_next;
      byte_counter  <= byte_counter_next;
      over_capacity <= over_capacity_next;
    end
  end

endmodule

>>> hdl/ppnd_skid.sv
// Two-entry result buffer: output register plus a skid register.
// Depends on ppnd_pkg for the result type.
module ppnd_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ppnd_pkg::ppnd_result_t push_data,
  output logic                   room,
  output logic                   out_valid,
  output ppnd_pkg::ppnd_result_t out_data,
  input  logic                   out_ready
);
  import ppnd_pkg::*;

  logic         main_valid;
  ppnd_result_t main_data;
  logic         skid_valid;
  ppnd_result_t skid_data;
  logic         pop;

  assign pop       = main_valid && out_ready;
  assign room      = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Control: refill the output register from the skid entry first
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !main_valid) begin
        main_valid <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (pop || !main_valid) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push && !skid_valid) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> dv/tb_packed_point_number_decoder_core.sv
// Self-checking testbench for packed_point_number_decoder_core: directed table, then random
// packed point-number records under several buffer capacities. Needs ppnd_pkg, ppnd_in_if,
// ppnd_out_if and the core; results are predicted byte by byte inside this file.
module tb_packed_point_number_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ppnd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 500;
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 60;
  localparam int DIR_ROWS      = 31;

  localparam ppnd_result_t NO_RES = '0;

  typedef enum logic [2:0] {
    DEC_IDLE, DEC_HEADER, DEC_COUNT_LO, DEC_RUN_CTRL, DEC_DELTA8, DEC_DELTA_HI, DEC_DELTA_LO
  } dec_state_t;

  // ROW_BYTE: checked against the predictor; ROW_TYPED: result given in the row
  typedef enum {ROW_BYTE, ROW_TYPED, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [BYTE_W-1:0]  b;
    bit                 st;
    bit                 en;
    logic [COUNT_W-1:0] cap;
    ppnd_result_t       want;
  } stim_row_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                st;
    bit                en;
  } byte_beat_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_wdata;

  ppnd_in_if  byte_ch();
  ppnd_out_if point_ch();

  packed_point_number_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_in   (byte_ch),
    .point_out (point_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // Decoder shadow state
  logic [COUNT_W-1:0] cap_q;
  dec_state_t         dec_state;
  logic [6:0]         hdr_hi;
  logic [COUNT_W-1:0] pt_count;
  logic [COUNT_W-1:0] pt_seen;
  logic [7:0]         run_rem;
  bit                 wide_run;
  logic [7:0]         delta_hi;
  logic [31:0]        run_sum;
  logic [BCNT_W-1:0]  nbytes;
  bit                 over_cap;

  ppnd_result_t queued_points[$];
  byte_beat_t   rec_q[$];

  bit          byte_gaps_on;
  bit          result_stalls_on;
  int          hold_cnt = 0;
  int          out_beats = 0;
  int          stall_seen = 0;
  int          fail_count = 0;
  int          quiet_cycles;
  int unsigned live_bytes = 0;
  int          caps_used = 0;
  int          results_checked = 0;
  int          completions = 0;
  int          invalid_seen = 0;
  int          overcap_seen = 0;
  ppnd_result_t head_point;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE,  8'h55, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h00, 1'b1, 1'b0, 15'd0,
      '{31'd0, 15'd0, 1'b0, 1'b1, 1'b1, 15'd0, 17'd1, ERR_NONE}},
    '{ROW_BYTE,  8'h80, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h00, 1'b0, 1'b0, 15'd0,
      '{31'd0, 15'd0, 1'b0, 1'b1, 1'b0, 15'd0, 17'd2, ERR_NONE}},
    '{ROW_BYTE,  8'h02, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h01, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'hFF, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h00, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h01, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h80, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'hFF, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'hFF, 1'b0, 1'b0, 15'd0,
      '{31'd65535, 15'd0, 1'b1, 1'b1, 1'b0, 15'd1, 17'd4, ERR_NONE}},
    '{ROW_BYTE,  8'h01, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h01, 1'b0, 1'b0, 15'd0,
      '{31'd0, 15'd0, 1'b0, 1'b1, 1'b0, 15'd0, 17'd0, ERR_INVALID}},
    '{ROW_BYTE,  8'h03, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h02, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h10, 1'b0, 1'b1, 15'd0,
      '{31'd16, 15'd0, 1'b1, 1'b1, 1'b0, 15'd0, 17'd0, ERR_INVALID}},
    '{ROW_BYTE,  8'h05, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h04, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h00, 1'b1, 1'b0, 15'd0,
      '{31'd0, 15'd0, 1'b0, 1'b1, 1'b1, 15'd0, 17'd1, ERR_NONE}},
    '{ROW_BYTE,  8'hFF, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'hFF, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'hFF, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'hAB, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h7F, 1'b0, 1'b1, 15'd0, NO_RES},
    '{ROW_CAP,   8'h00, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h01, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_BYTE,  8'h00, 1'b0, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h7F, 1'b0, 1'b0, 15'd0,
      '{31'd127, 15'd0, 1'b1, 1'b1, 1'b0, 15'd1, 17'd0, ERR_BUFFER}},
    '{ROW_BYTE,  8'h02, 1'b1, 1'b0, 15'd0, NO_RES},
    '{ROW_TYPED, 8'h05, 1'b0, 1'b0, 15'd0,
      '{31'd0, 15'd0, 1'b0, 1'b1, 1'b0, 15'd0, 17'd0, ERR_INVALID}}
  };

  // Latch the header count; a zero count ends the record at once
  function automatic void take_count(input logic [COUNT_W-1:0] c, inout bit done);
    pt_count = c;
    over_cap = (c > cap_q);
    if (c == '0) done = 1'b1;
    else dec_state = DEC_RUN_CTRL;
  endfunction

  // Accumulate one delta and emit the running sum as the next point
  function automatic void add_delta(input logic [15:0] d, inout bit done,
                                    inout ppnd_result_t res);
    run_sum = run_sum + 32'(d);
    res.point_valid  = 1'b1;
    res.point_number = run_sum[NUM_W-1:0];
    res.point_index  = pt_seen;
    pt_seen = pt_seen + COUNT_W'(1);
    run_rem = run_rem - 8'd1;
    if (pt_seen == pt_count) done = 1'b1;
    else if (run_rem == '0) dec_state = DEC_RUN_CTRL;
    else dec_state = wide_run ? DEC_DELTA_HI : DEC_DELTA8;
  endfunction

  // Advance the shadow decoder by one byte; return 1 when the byte yields a result
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input bit st, input bit en,
                                     output ppnd_result_t res);
    bit         done;
    bit         allp;
    logic [1:0] err;
    done = 1'b0;
    allp = 1'b0;
    err  = ERR_NONE;
    res  = '0;
    if (st) begin
      dec_state = DEC_HEADER;
      hdr_hi    = '0;
      pt_count  = '0;
      pt_seen   = '0;
      run_rem   = '0;
      wide_run  = 1'b0;
      delta_hi  = '0;
      run_sum   = '0;
      nbytes    = '0;
      over_cap  = 1'b0;
    end
    if (dec_state == DEC_IDLE) return 1'b0;
    nbytes = nbytes + BCNT_W'(1);
    case (dec_state)
      DEC_HEADER: begin
        if (b == '0) begin
          done = 1'b1;
          allp = 1'b1;
        end else if (b[7]) begin
          hdr_hi    = b[6:0];
          dec_state = DEC_COUNT_LO;
        end else begin
          take_count({8'd0, b[6:0]}, done);
        end
      end
      DEC_COUNT_LO: take_count({hdr_hi, b}, done);
      DEC_RUN_CTRL: begin
        if (int'(b[6:0]) + 1 > int'(pt_count) - int'(pt_seen)) begin
          done = 1'b1;
          err  = ERR_INVALID;
        end else begin
          run_rem   = {1'b0, b[6:0]} + 8'd1;
          wide_run  = b[7];
          dec_state = b[7] ? DEC_DELTA_HI : DEC_DELTA8;
        end
      end
      DEC_DELTA8: add_delta({8'd0, b}, done, res);
      DEC_DELTA_HI: begin
        delta_hi  = b;
        dec_state = DEC_DELTA_LO;
      end
      DEC_DELTA_LO: add_delta({delta_hi, b}, done, res);
      default: dec_state = DEC_IDLE;
    endcase
    // Truncated record
    if (!done && en) begin
      done = 1'b1;
      err  = ERR_INVALID;
    end
    if (done) begin
      dec_state = DEC_IDLE;
      if (err == ERR_NONE && over_cap) err = ERR_BUFFER;
    end
    res.record_done = done;
    res.full_set    = allp;
    res.point_total = (done && err != ERR_INVALID) ? pt_count : '0;
    res.used_bytes  = (done && err == ERR_NONE) ? nbytes : '0;
    res.error_code  = err;
    return res.point_valid || done;
  endfunction

  // Drive one beat, with a random lead-in gap when byte_gaps_on, then queue any expected result
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit st, input bit en,
                           input bit typed, input ppnd_result_t want);
    int           gap;
    bit           has_res;
    ppnd_result_t pred;
    gap = byte_gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid        = 1'b1;
    byte_ch.data_byte    = b;
    byte_ch.record_start = st;
    byte_ch.data_end     = en;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    if (st || dec_state != DEC_IDLE) live_bytes++;
    has_res = decode_byte(b, st, en, pred);
    if (typed) queued_points.push_back(want);
    else if (has_res) queued_points.push_back(pred);
  endtask

  // Hold off the sender until every queued result is back and the core has settled
  task automatic drain_results();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (queued_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cap_q  = v;
    caps_used++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    rec_q.push_back('{b, 1'b0, 1'b0});
  endtask

  // Well-formed record of n points: header, then runs of random width and content
  task automatic add_wellformed(input int unsigned n);
    int unsigned left;
    int unsigned run;
    bit          wide;
    if (n < 128 && $urandom_range(0, 3) != 0) begin
      push_byte(8'(n));
    end else begin
      push_byte({1'b1, 7'(n >> 8)});
      push_byte(8'(n));
    end
    left = n;
    while (left > 0) begin
      run = $urandom_range(1, (left < 8) ? left : 8);
      if ($urandom_range(0, 15) == 0) run = (left < 128) ? left : 128;
      wide = 1'($urandom_range(0, 1));
      push_byte({wide, 7'(run - 1)});
      repeat (run) begin
        push_byte(8'($urandom_range(0, 255)));
        if (wide) push_byte(8'($urandom_range(0, 255)));
      end
      left -= run;
    end
  endtask

  // Pick one record shape: mostly well-formed, some broken, some noise
  task automatic build_record();
    int          kind;
    int unsigned n;
    int unsigned cut;
    rec_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      if ($urandom_range(0, 1) == 0) begin
        push_byte(8'h00);
      end else begin
        push_byte(8'h80);
        push_byte(8'h00);
      end
    end else if (kind < 14) begin
      n = $urandom_range(1, 20);
      push_byte(8'(n));
      push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(n, 127))});
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 4))
        rec_q.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))});
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
      add_wellformed(n);
      if (kind < 38) begin
        // cut short: with data_end set for truncation, without for an abandoned record
        cut = $urandom_range(0, rec_q.size() - 2);
        while (rec_q.size() > cut + 1) void'(rec_q.pop_back());
        if (kind < 30) rec_q[cut].en = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        rec_q[rec_q.size() - 1].en = 1'b1;
      end
    end
    if (kind < 14 || kind >= 18) rec_q[0].st = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result sink: after each taken beat, draw a random stall when result_stalls_on and hold ready low for it
  always @(negedge clk) begin
    if (rst) begin
      point_ch.ready = 1'b0;
    end else begin
      if (stall_seen != out_beats) begin
        stall_seen = out_beats;
        hold_cnt   = result_stalls_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_cnt != 0) begin
        point_ch.ready = 1'b0;
        hold_cnt--;
      end else begin
        point_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest queued expectation
  always @(posedge clk) begin
    if (!rst && point_ch.valid === 1'b1 && point_ch.ready === 1'b1) begin
      if (queued_points.size() == 0) begin
        $error("result beat with nothing expected: point_number 0x%0h, record_done %0b",
               point_ch.point_number, point_ch.record_done);
        fail_count++;
      end else begin
        head_point = queued_points.pop_front();
        check_field("point_number", 32'(head_point.point_number), 32'(point_ch.point_number));
        check_field("point_index", 32'(head_point.point_index), 32'(point_ch.point_index));
        check_field("point_valid", 32'(head_point.point_valid), 32'(point_ch.point_valid));
        check_field("record_done", 32'(head_point.record_done), 32'(point_ch.record_done));
        check_field("full_set", 32'(head_point.full_set), 32'(point_ch.full_set));
        check_field("point_total", 32'(head_point.point_total), 32'(point_ch.point_total));
        check_field("used_bytes", 32'(head_point.used_bytes), 32'(point_ch.used_bytes));
        check_field("error_code", 32'(head_point.error_code), 32'(point_ch.error_code));
        results_checked++;
        if (head_point.record_done) completions++;
        if (head_point.error_code == ERR_INVALID) invalid_seen++;
        if (head_point.error_code == ERR_BUFFER) overcap_seen++;
      end
      out_beats++;
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
          (point_ch.valid === 1'b1 && point_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_packed_point_number_decoder_core: FAIL");
    $finish;
  end

  initial begin
    int                 ph;
    int unsigned        phase_base;
    logic [COUNT_W-1:0] caps [PHASES];
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = '0;
    byte_ch.record_start = 1'b0;
    byte_ch.data_end     = 1'b0;
    cap_q                = CAP_RESET;
    dec_state            = DEC_IDLE;
    byte_gaps_on         = 1'b1;
    result_stalls_on     = 1'b1;
    caps[0] = CAP_RESET;
    caps[1] = '0;
    caps[2] = 15'd6;
    caps[3] = 15'($urandom_range(1, 40));
    caps[4] = 15'd1;
    caps[5] = 15'($urandom_range(0, 32767));
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        drain_results();
        write_cap(dir_rows[i].cap);
      end else begin
        send_byte(dir_rows[i].b, dir_rows[i].st, dir_rows[i].en,
                  dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
      end
    end

    // Random records, one capacity setting per phase
    for (ph = 0; ph < PHASES; ph++) begin
      if (dec_state != DEC_IDLE)
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_RES);
      drain_results();
      write_cap(caps[ph]);
      byte_gaps_on     = (ph != 0) && (ph != 2);
      result_stalls_on = (ph >= 2);
      phase_base       = live_bytes;
      while (live_bytes - phase_base < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) drain_results();
        build_record();
        foreach (rec_q[k])
          send_byte(rec_q[k].b, rec_q[k].st, rec_q[k].en, 1'b0, NO_RES);
      end
    end

    // Close any open record, then let everything drain
    if (dec_state != DEC_IDLE)
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_RES);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Decoded %0d record bytes under %0d capacity settings; %0d result beats checked.",
             live_bytes, caps_used, results_checked);
    $display("Records completed: %0d, invalid: %0d, over capacity: %0d.",
             completions, invalid_seen, overcap_seen);
    if (fail_count == 0)
      $display("tb_packed_point_number_decoder_core: PASS");
    else
      $display("tb_packed_point_number_decoder_core: FAIL");
    $finish;
  end

endmodule
